FILE: sv/lkvc_pkg.sv
// lkvc_pkg: shared types and constants for the LRU key-value cache.
// Used by the top level, sequencer and datapath; depends on nothing.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 31;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam int CAP_BITS   = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);
    localparam int RD_BITS    = 32;
    localparam logic [RD_BITS-1:0] RD_MISS = '1;

    typedef enum logic
    {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic load;     // capture input beat
        logic exec;     // apply lookup result to store
        logic out_pop;  // result beat taken
    } cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        logic res_valid;
    } sts_t;

endpackage

FILE: sv/lru_key_value_cache.sv
// lru_key_value_cache: top level, joins sequencer and datapath.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_dp.
//
//  channel  | dir | tdata (low bit up)                        | tuser
//  s_axis   | in  | key[15:0], value[46:16], pad to 48        | operation
//  m_axis   | out | read_value[31:0], evicted_key[47:32]      | hit, evicted
//  cfg      | in  | capacity_in_use[4:0]                      | -
//
// Each beat passes through capture, lookup/update and result, in that order.
// The lookup cycle does all key compares and rank updates in parallel.
// The result register holds until m_axis_tready; no new beat is taken
// until it is gone. Reset empties the store at once, no clearing pass.
module lru_key_value_cache
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,        // capacity_in_use
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,    // key[15:0], value[46:16], 0
    input  logic        s_axis_tuser,    // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,    // read_value[31:0], evicted_key[47:32]
    output logic [1:0]  m_axis_tuser     // hit[0], evicted[1]
);

    lkvc_pkg::cmd_t cmd;
    lkvc_pkg::sts_t sts;
    logic           in_fire, out_fire;
    logic           hit, ev;
    logic [31:0]    rd;
    logic [15:0]    evk;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    lkvc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .sts      (sts),
        .cmd      (cmd),
        .in_rdy   (s_axis_tready)
    );

    lkvc_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_op    (s_axis_tuser),
        .in_key   (s_axis_tdata[15:0]),
        .in_value (s_axis_tdata[46:16]),
        .sts      (sts),
        .res_hit  (hit),
        .res_rd   (rd),
        .res_ev   (ev),
        .res_evk  (evk)
    );

    assign m_axis_tvalid = sts.res_valid;
    assign m_axis_tdata  = {evk, rd};
    assign m_axis_tuser  = {ev, hit};

endmodule

FILE: sv/lkvc_ctrl.sv
// lkvc_ctrl: sequencer for one request at a time.
// Depends on lkvc_pkg.
module lkvc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_fire,
    input  lkvc_pkg::sts_t   sts,
    output lkvc_pkg::cmd_t   cmd,
    output logic             in_rdy
);

    lkvc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE: if (in_fire) state_next = lkvc_pkg::ST_LOOK;
            lkvc_pkg::ST_LOOK: state_next = lkvc_pkg::ST_DONE;
            lkvc_pkg::ST_DONE: if (out_fire) state_next = lkvc_pkg::ST_IDLE;
            default:           state_next = lkvc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        in_rdy  = 1'b0;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                in_rdy   = 1'b1;
                cmd.load = in_fire;
            end
            lkvc_pkg::ST_LOOK: cmd.exec = 1'b1;
            lkvc_pkg::ST_DONE: cmd.out_pop = out_fire && sts.res_valid;
            default: ;
        endcase
    end

endmodule

FILE: sv/lkvc_dp.sv
// lkvc_dp: entry stores, parallel key compare, rank update, result register.
// Depends on lkvc_pkg.
module lkvc_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lkvc_pkg::cmd_t                      cmd,
    input  logic                                cfg_we,
    input  logic [lkvc_pkg::CAP_BITS-1:0]       cfg_data,
    input  logic                                in_op,
    input  logic [lkvc_pkg::KEY_BITS-1:0]       in_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0]     in_value,
    output lkvc_pkg::sts_t                      sts,
    output logic                                res_hit,
    output logic [lkvc_pkg::RD_BITS-1:0]        res_rd,
    output logic                                res_ev,
    output logic [lkvc_pkg::KEY_BITS-1:0]       res_evk
);

    localparam int N  = lkvc_pkg::ENTRIES;
    localparam int IB = lkvc_pkg::IDX_BITS;
    localparam int CB = lkvc_pkg::CNT_BITS;

    logic [lkvc_pkg::CAP_BITS-1:0]   cap_reg;
    logic                            op_reg;
    logic [lkvc_pkg::KEY_BITS-1:0]   key_reg;
    logic [lkvc_pkg::VALUE_BITS-1:0] val_reg;
    logic [N-1:0]                    vld_reg;
    logic [IB-1:0]                   rank_reg [N];
    logic [lkvc_pkg::KEY_BITS-1:0]   ekey_reg [N];
    logic [lkvc_pkg::VALUE_BITS-1:0] eval_reg [N];
    logic [CB-1:0]                   used_reg;
    logic                            rv_reg;
    logic                            hit_reg, ev_reg;
    logic [lkvc_pkg::RD_BITS-1:0]    rd_reg;
    logic [lkvc_pkg::KEY_BITS-1:0]   evk_reg;

    logic [N-1:0]  match;
    logic          found;
    logic [IB-1:0] fidx, free_idx, lru_idx, slot;
    logic          have_free, have_lru, do_ins, do_ev;
    logic [CB-1:0] cap_eff;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i] = vld_reg[i] && (ekey_reg[i] == key_reg);
        end
    end

    // priority encoders: lowest index wins
    always_comb
    begin
        found = 1'b0; fidx = '0;
        have_free = 1'b0; free_idx = '0;
        have_lru = 1'b0; lru_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found = 1'b1; fidx = IB'(i);
            end
            if (!vld_reg[i])
            begin
                have_free = 1'b1; free_idx = IB'(i);
            end
            // least recent holds rank used-1, unique among valid entries
            if (vld_reg[i] && (CB'(rank_reg[i]) == used_reg - CB'(1)))
            begin
                have_lru = 1'b1; lru_idx = IB'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CB'(1);
        else if (32'(cap_reg) > N)
            cap_eff = CB'(N);
        else
            cap_eff = CB'(cap_reg);
        do_ins = !found && (op_reg == lkvc_pkg::OP_PUT);
        do_ev  = do_ins && !((used_reg < cap_eff) && have_free) && have_lru;
        if (do_ev)
            slot = lru_idx;
        else if ((used_reg < cap_eff) && have_free)
            slot = free_idx;
        else
            slot = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= lkvc_pkg::CAP_RESET;
            vld_reg  <= '0;
            used_reg <= '0;
            rv_reg   <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (cmd.exec)
            begin
                rv_reg <= 1'b1;
                if (found)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (i == 32'(fidx))
                            rank_reg[i] <= '0;
                        else if (vld_reg[i] && rank_reg[i] < rank_reg[fidx])
                            rank_reg[i] <= rank_reg[i] + IB'(1);
                    end
                end
                else if (do_ins)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (i == 32'(slot))
                            rank_reg[i] <= '0;
                        else if (vld_reg[i])
                            rank_reg[i] <= rank_reg[i] + IB'(1);
                    end
                    vld_reg[slot] <= 1'b1;
                    if (!do_ev)
                        used_reg <= used_reg + CB'(1);
                end
            end
            else if (cmd.out_pop)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_op;
            key_reg <= in_key;
            val_reg <= in_value;
        end
        if (cmd.exec)
        begin
            hit_reg <= found;
            ev_reg  <= do_ev;
            evk_reg <= do_ev ? ekey_reg[lru_idx] : '0;
            if (op_reg == lkvc_pkg::OP_PUT)
                rd_reg <= '0;
            else if (found)
                rd_reg <= {1'b0, eval_reg[fidx]};
            else
                rd_reg <= lkvc_pkg::RD_MISS;
            if (found && op_reg == lkvc_pkg::OP_PUT)
                eval_reg[fidx] <= val_reg;
            if (do_ins)
            begin
                ekey_reg[slot] <= key_reg;
                eval_reg[slot] <= val_reg;
            end
        end
    end

    assign sts.res_valid = rv_reg;
    assign res_hit = hit_reg;
    assign res_rd  = rd_reg;
    assign res_ev  = ev_reg;
    assign res_evk = evk_reg;

endmodule

FILE: sv/lkvc_checker.sv
// lkvc_checker: port-level checks for lru_key_value_cache, bound to the top.
// Depends on nothing but the top level's ports.
module lkvc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // one beat at a time: never ready while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // eviction only with a miss
    a_ev_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("eviction on hit");

    // no eviction means zero evicted key
    a_evk: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[47:32] == 16'h0)
        else $error("stray evicted key");

    // an accepted beat yields a registered result after the lookup state
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("result missing");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/lru_key_value_cache_checker.sv
// lru_key_value_cache_checker: watches both streams, predicts each result beat
// from its own LRU store model and compares. Depends on lkvc_pkg.
`timescale 1ns / 100ps
module lru_key_value_cache_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct packed
    {
        logic                          hit;
        logic [lkvc_pkg::RD_BITS-1:0]  read_value;
        logic                          evicted;
        logic [lkvc_pkg::KEY_BITS-1:0] evicted_key;
    } lookup_res_t;

    logic                            mdl_valid [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::KEY_BITS-1:0]   mdl_key   [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::VALUE_BITS-1:0] mdl_value [lkvc_pkg::ENTRIES];
    int unsigned                     mdl_rank  [lkvc_pkg::ENTRIES];
    int unsigned                     mdl_used;
    logic [lkvc_pkg::CAP_BITS-1:0]   mdl_cap;
    lookup_res_t                     expected_q[$];

    assign pending = expected_q.size();

    function automatic lookup_res_t cache_access(lkvc_pkg::op_t op,
                                                 logic [lkvc_pkg::KEY_BITS-1:0] k,
                                                 logic [lkvc_pkg::VALUE_BITS-1:0] v);
        lookup_res_t r;
        int found;
        int slot;
        int unsigned cap;
        int unsigned best;
        int unsigned old;
        r = '0;
        found = -1;
        slot = -1;
        best = 0;
        cap = (mdl_cap == 0) ? 1 :
              ((mdl_cap > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : mdl_cap);
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (found < 0 && mdl_valid[i] && mdl_key[i] == k)
                found = i;
        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (op == lkvc_pkg::OP_GET)
                r.read_value = lkvc_pkg::RD_BITS'(mdl_value[found]);
            else
                mdl_value[found] = v;
            old = mdl_rank[found];
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                if (i != found && mdl_valid[i] && mdl_rank[i] < old)
                    mdl_rank[i]++;
            mdl_rank[found] = 0;
        end
        else if (op == lkvc_pkg::OP_GET)
            r.read_value = lkvc_pkg::RD_MISS;
        else
        begin
            if (mdl_used < cap)
                for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                    if (slot < 0 && !mdl_valid[i])
                        slot = i;
            if (slot < 0)
            begin
                // oldest entry carries the largest rank
                for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                    if (mdl_valid[i] && (slot < 0 || mdl_rank[i] > best))
                    begin
                        slot = i;
                        best = mdl_rank[i];
                    end
                r.evicted = 1'b1;
                r.evicted_key = mdl_key[slot];
                mdl_valid[slot] = 1'b0;
                mdl_used--;
            end
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
                if (mdl_valid[i])
                    mdl_rank[i]++;
            mdl_valid[slot] = 1'b1;
            mdl_key[slot] = k;
            mdl_value[slot] = v;
            mdl_rank[slot] = 0;
            mdl_used++;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_res_t want;
        lookup_res_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            begin
                mdl_valid[i] = 1'b0;
                mdl_key[i] = '0;
                mdl_value[i] = '0;
                mdl_rank[i] = 0;
            end
            mdl_used = 0;
            mdl_cap = lkvc_pkg::CAP_RESET;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                mdl_cap = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit = m_axis_tuser[0];
                got.evicted = m_axis_tuser[1];
                got.read_value = m_axis_tdata[31:0];
                got.evicted_key = m_axis_tdata[47:32];
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.hit !== want.hit)
                    begin
                        $error("hit exp %0h got %0h", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value exp %0h got %0h", want.read_value,
                               got.read_value);
                        fail_count++;
                    end
                    if (got.evicted !== want.evicted)
                    begin
                        $error("evicted exp %0h got %0h", want.evicted, got.evicted);
                        fail_count++;
                    end
                    if (got.evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key exp %0h got %0h", want.evicted_key,
                               got.evicted_key);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(cache_access(lkvc_pkg::op_t'(s_axis_tuser),
                                                  s_axis_tdata[15:0],
                                                  s_axis_tdata[46:16]));
        end
    end

endmodule

FILE: tb/lru_key_value_cache_tb.sv
// lru_key_value_cache_tb: stimulus and verdict for the LRU key-value cache.
// Depends on lkvc_pkg, lru_key_value_cache and lru_key_value_cache_checker.
`timescale 1ns / 100ps
module lru_key_value_cache_tb;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          pending;
    int          cycle_count;
    bit          long_hold;   // asks the sink to hold off for a long stretch

    lru_key_value_cache uut
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    lru_key_value_cache_checker u_checker
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // sink: own stall pattern; a long hold-off fills the block up on demand
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                for (int i = 0; i < 60; i++)
                    @(negedge clk);
                long_hold = 1'b0;
            end
            else if (cycle_count % 500 < 150)
                m_axis_tready <= 1'b1;            // stretch with no stalls
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // one beat; bursts and gaps come from the caller
    task automatic send_request(lkvc_pkg::op_t op, logic [lkvc_pkg::KEY_BITS-1:0] k,
                                logic [lkvc_pkg::VALUE_BITS-1:0] v);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, v, k};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        s_axis_tvalid <= 1'b0;
        for (int i = 0; i < n; i++)
            @(negedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        for (int i = 0; i < 8; i++)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [4:0] c);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // random traffic from a small key pool so hits and evictions are common
    task automatic random_phase(int n, int pool);
        int burst;
        logic [lkvc_pkg::KEY_BITS-1:0] k;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                idle_gap($urandom_range(0, 4));
                burst = $urandom_range(1, 12);
            end
            burst--;
            if ($urandom_range(0, 9) == 0)
                k = lkvc_pkg::KEY_BITS'($urandom());
            else
                k = lkvc_pkg::KEY_BITS'($urandom_range(0, pool - 1)) ^ 16'hA5C3;
            send_request(lkvc_pkg::op_t'($urandom_range(0, 1)), k,
                         lkvc_pkg::VALUE_BITS'($urandom()));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        long_hold = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty get, extremes, fill past 16, hit/promote, miss
        send_request(lkvc_pkg::OP_GET, 16'h0000, '0);
        send_request(lkvc_pkg::OP_PUT, 16'hFFFF, 31'h7FFF_FFFF);
        send_request(lkvc_pkg::OP_PUT, 16'h0000, 31'h0000_0000);
        send_request(lkvc_pkg::OP_GET, 16'hFFFF, '1);
        send_request(lkvc_pkg::OP_GET, 16'h0000, '0);
        for (int i = 1; i <= 15; i++)
            send_request(lkvc_pkg::OP_PUT, lkvc_pkg::KEY_BITS'(i),
                         lkvc_pkg::VALUE_BITS'(i * 3));
        send_request(lkvc_pkg::OP_PUT, 16'h0000, 31'h5555_5555);   // put hit overwrites
        send_request(lkvc_pkg::OP_GET, 16'h1234, '0);              // get miss
        send_request(lkvc_pkg::OP_GET, 16'h0000, '0);
        drain();

        // capacity lowered while the store holds more
        write_capacity(5'd3);
        send_request(lkvc_pkg::OP_PUT, 16'h0100, 31'h2AAA_AAAA);
        send_request(lkvc_pkg::OP_PUT, 16'h0101, 31'h1);
        drain();
        write_capacity(5'd0);                            // acts as one
        random_phase(40, 4);
        drain();
        write_capacity(5'd31);                           // saturates
        random_phase(60, 24);

        // long sink hold-off while the source keeps offering
        long_hold = 1'b1;
        random_phase(30, 24);
        drain();
        write_capacity(5'd1);
        random_phase(50, 3);
        drain();
        write_capacity(5'd16);
        random_phase(120, 20);
        drain();
        write_capacity(5'd6);
        random_phase(100, 10);
        drain();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lkvc_pkg.sv
sv/lkvc_ctrl.sv
sv/lkvc_dp.sv
sv/lru_key_value_cache.sv
sv/lkvc_checker.sv
tb/lru_key_value_cache_checker.sv
tb/lru_key_value_cache_tb.sv
